FILE: src/avar_pkg.sv
// shared constants, types and codes of the adc voltage ascii reporter
`timescale 1ns / 1ps
`default_nettype none
package avar_pkg;

	localparam int unsigned SAMPLE_BITS = 10;
	localparam int unsigned REF_BITS    = 14;
	localparam int unsigned PROD_BITS   = SAMPLE_BITS + REF_BITS;
	localparam int unsigned MV_BITS     = 14;
	localparam int unsigned REM3_BITS   = 10;
	localparam int unsigned REM2_BITS   = 7;

	localparam logic [REF_BITS-1:0]    REF_RESET   = REF_BITS'(5000);
	localparam logic [PROD_BITS-1:0]   SAMPLE_FULL = PROD_BITS'((1 << SAMPLE_BITS) - 1);
	localparam logic [MV_BITS-1:0]     MV_MAX      = MV_BITS'(9999);

	localparam int unsigned APB_ADDR_BITS = 2;
	localparam int unsigned APB_DATA_BITS = 32;
	localparam logic [APB_ADDR_BITS-1:0] ADDR_REF_MV = '0;

	localparam logic [7:0] CMD_CH0    = 8'h61;
	localparam logic [7:0] CMD_CH1    = 8'h62;
	localparam logic [7:0] CMD_CH7    = 8'h63;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_DOT  = 8'h2E;
	localparam logic [7:0] ASCII_V    = 8'h56;
	localparam logic [7:0] ASCII_LF   = 8'h0A;

	localparam int unsigned QUEUE_DEPTH = 8;
	localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_BITS   = QPTR_BITS + 1;
	localparam int unsigned OCC_BITS    = QCNT_BITS + 1;

	typedef struct packed {
		logic [3:0] d3;
		logic [3:0] d2;
		logic [3:0] d1;
		logic [3:0] d0;
	} avar_digits_t;

	typedef struct packed {
		logic                 empty;
		logic [QCNT_BITS-1:0] level;
	} avar_qstat_t;

	typedef enum logic [6:0] {
		ST_VOLT = 7'b0000001,
		ST_DOT  = 7'b0000010,
		ST_HUND = 7'b0000100,
		ST_TENS = 7'b0001000,
		ST_ONES = 7'b0010000,
		ST_UNIT = 7'b0100000,
		ST_EOL  = 7'b1000000
	} avar_char_st_t;

endpackage
`default_nettype wire

FILE: src/avar_front.sv
// front end: command decode, scaling to millivolts and decimal digit split
`timescale 1ns / 1ps
`default_nettype none
module avar_front
	import avar_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             rx_byte,
	input  wire logic [SAMPLE_BITS-1:0] sample_ch0,
	input  wire logic [SAMPLE_BITS-1:0] sample_ch1,
	input  wire logic [SAMPLE_BITS-1:0] sample_ch7,
	input  wire logic [REF_BITS-1:0]    ref_mv,
	input  wire avar_qstat_t            qstat,
	output logic                        push,
	output avar_digits_t                push_data
);

	logic                   v_s1, v_s2, v_s3, v_s4;
	logic [PROD_BITS-1:0]   prod_s1;
	logic [MV_BITS-1:0]     mv_s2;
	logic [3:0]             d3_s3, d3_s4;
	logic [REM3_BITS-1:0]   rem3_s3;
	logic [3:0]             d2_s4;
	logic [REM2_BITS-1:0]   rem2_s4;

	logic                   cmd_hit;
	logic [SAMPLE_BITS-1:0] code_sel;
	logic [OCC_BITS-1:0]    occ;
	logic                   accept;

	logic [PROD_BITS-1:0]   q_a, r_a, q_b, r_b, q_sum;
	logic [MV_BITS-1:0]     mv_next;

	logic [3:0]             d3_next, d2_next, d1_next;
	logic [MV_BITS-1:0]     sub3;
	logic [REM3_BITS-1:0]   sub2;
	logic [REM2_BITS-1:0]   sub1;

	// credit check: queued entries plus items still in the pipe
	assign occ = OCC_BITS'(qstat.level) + OCC_BITS'(v_s1) + OCC_BITS'(v_s2)
		+ OCC_BITS'(v_s3) + OCC_BITS'(v_s4);
	assign in_stall = (occ >= OCC_BITS'(QUEUE_DEPTH));
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd_hit  = 1'b1;
		code_sel = sample_ch0;
		case (rx_byte)
			CMD_CH0: code_sel = sample_ch0;
			CMD_CH1: code_sel = sample_ch1;
			CMD_CH7: code_sel = sample_ch7;
			default: cmd_hit = 1'b0;
		endcase
	end

	// divide by 2^n-1: fold the high part back twice, then one correction
	always_comb begin
		q_a   = prod_s1 >> SAMPLE_BITS;
		r_a   = (prod_s1 & SAMPLE_FULL) + q_a;
		q_b   = r_a >> SAMPLE_BITS;
		r_b   = (r_a & SAMPLE_FULL) + q_b;
		q_sum = q_a + q_b + PROD_BITS'(r_b >= SAMPLE_FULL);
		if (q_sum > PROD_BITS'(MV_MAX)) begin
			mv_next = MV_MAX;
		end else begin
			mv_next = q_sum[MV_BITS-1:0];
		end
	end

	always_comb begin
		d3_next = '0;
		sub3    = '0;
		for (int k = 1; k <= 9; k++) begin
			if (mv_s2 >= MV_BITS'(k * 1000)) begin
				d3_next = 4'(k);
				sub3    = MV_BITS'(k * 1000);
			end
		end
	end

	always_comb begin
		d2_next = '0;
		sub2    = '0;
		for (int k = 1; k <= 9; k++) begin
			if (rem3_s3 >= REM3_BITS'(k * 100)) begin
				d2_next = 4'(k);
				sub2    = REM3_BITS'(k * 100);
			end
		end
	end

	always_comb begin
		d1_next = '0;
		sub1    = '0;
		for (int k = 1; k <= 9; k++) begin
			if (rem2_s4 >= REM2_BITS'(k * 10)) begin
				d1_next = 4'(k);
				sub1    = REM2_BITS'(k * 10);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept && cmd_hit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_BITS'(code_sel) * PROD_BITS'(ref_mv);
		mv_s2   <= mv_next;
		d3_s3   <= d3_next;
		rem3_s3 <= REM3_BITS'(mv_s2 - sub3);
		d3_s4   <= d3_s3;
		d2_s4   <= d2_next;
		rem2_s4 <= REM2_BITS'(rem3_s3 - sub2);
	end

	assign push         = v_s4;
	assign push_data.d3 = d3_s4;
	assign push_data.d2 = d2_s4;
	assign push_data.d1 = d1_next;
	assign push_data.d0 = 4'(rem2_s4 - sub1);

endmodule
`default_nettype wire

FILE: src/avar_queue.sv
// short register queue of digit sets between front and back
`timescale 1ns / 1ps
`default_nettype none
module avar_queue
	import avar_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire avar_digits_t push_data,
	input  wire logic         pop,
	output avar_digits_t      pop_data,
	output avar_qstat_t       qstat
);

	avar_digits_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data    = mem_q[rd_ptr_q];
	assign qstat.empty = (level_q == '0);
	assign qstat.level = level_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && level_q == QCNT_BITS'(QUEUE_DEPTH)))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && level_q == '0))
		else $error("queue underflow");

	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (level_q == $past(level_q) + 1'b1))
		else $error("queue level did not follow push");

endmodule
`default_nettype wire

FILE: src/avar_back.sv
// back end: walks one digit set through the seven characters of the report
`timescale 1ns / 1ps
`default_nettype none
module avar_back
	import avar_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire avar_qstat_t  qstat,
	input  wire avar_digits_t entry,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [7:0]        char_out,
	output logic              last_char
);

	avar_char_st_t state_q, state_next;
	logic          valid_q;
	logic [7:0]    char_q, char_next;
	logic          last_q;
	logic          adv, take;

	assign adv  = !valid_q || !out_stall;
	assign take = adv && !qstat.empty;
	assign pop  = take && (state_q == ST_EOL);

	always_comb begin
		state_next = ST_VOLT;
		char_next  = ASCII_LF;
		case (state_q)
			ST_VOLT: begin
				state_next = ST_DOT;
				char_next  = ASCII_ZERO + 8'(entry.d3);
			end
			ST_DOT: begin
				state_next = ST_HUND;
				char_next  = ASCII_DOT;
			end
			ST_HUND: begin
				state_next = ST_TENS;
				char_next  = ASCII_ZERO + 8'(entry.d2);
			end
			ST_TENS: begin
				state_next = ST_ONES;
				char_next  = ASCII_ZERO + 8'(entry.d1);
			end
			ST_ONES: begin
				state_next = ST_UNIT;
				char_next  = ASCII_ZERO + 8'(entry.d0);
			end
			ST_UNIT: begin
				state_next = ST_EOL;
				char_next  = ASCII_V;
			end
			ST_EOL: begin
				state_next = ST_VOLT;
				char_next  = ASCII_LF;
			end
			default: begin
				state_next = ST_VOLT;
				char_next  = ASCII_LF;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_VOLT;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= take;
			if (take) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_q <= char_next;
			last_q <= (state_q == ST_EOL);
		end
	end

	assign out_valid = valid_q;
	assign char_out  = char_q;
	assign last_char = last_q;

	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && last_q) |-> (char_q == ASCII_LF))
		else $error("last character is not a newline");

	a_pop_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (valid_q && last_q && state_q == ST_VOLT))
		else $error("entry released before its newline");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("character state lost one-hot encoding");

endmodule
`default_nettype wire

FILE: src/adc_voltage_ascii_reporter.sv
// top level: reference register, front end, digit queue and character back end
//
// input channel (in_valid/in_stall): one transaction carries a command byte and
// the current codes of channels 0, 1 and 7. bytes 'a', 'b', 'c' pick channel
// 0, 1 or 7; every other byte is taken and dropped with no output.
// output channel (out_valid/out_stall): one character per transaction, seven
// per command: volts digit, '.', three millivolt digits, 'V', newline. the
// newline carries last_char.
// the apb port holds reference_millivolts at address 0 (reset value 5000);
// the user must see that it is written only while the block is idle, which
// the block itself does not enforce. a taken command passes four front
// stages, the first loaded at the accepting edge, then the queue write and
// the output register before its first character is valid. the character
// unit sends one character per cycle while an entry waits and out_stall is
// low; the input side takes one command per cycle until eight commands sit
// in the front stages and the queue together, then raises in_stall.
// a stall on the output holds the character register and backs up the queue.
// reset empties the front stages and the queue and restores the reference.
`timescale 1ns / 1ps
`default_nettype none
module adc_voltage_ascii_reporter
	import avar_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0]      prdata,
	output logic                          pready,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [7:0]               rx_byte,
	input  wire logic [SAMPLE_BITS-1:0]   sample_ch0,
	input  wire logic [SAMPLE_BITS-1:0]   sample_ch1,
	input  wire logic [SAMPLE_BITS-1:0]   sample_ch7,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [7:0]                    char_out,
	output logic                          last_char
);

	logic [REF_BITS-1:0] ref_mv_q;
	avar_qstat_t         qstat;
	avar_digits_t        push_data, pop_data;
	logic                push, pop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_mv_q <= REF_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_REF_MV) begin
			ref_mv_q <= pwdata[REF_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_REF_MV) begin
			prdata = APB_DATA_BITS'(ref_mv_q);
		end
	end

	avar_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.sample_ch0 (sample_ch0),
		.sample_ch1 (sample_ch1),
		.sample_ch7 (sample_ch7),
		.ref_mv     (ref_mv_q),
		.qstat      (qstat),
		.push       (push),
		.push_data  (push_data)
	);

	avar_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	avar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.entry     (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_out  (char_out),
		.last_char (last_char)
	);

endmodule
`default_nettype wire
